// ----- hw/rtl/slfp_pkg.sv -----
// ----------------------------------------------------------------------------
// slfp_pkg
// Shared types and constants of the sync/length frame parser.
// ----------------------------------------------------------------------------
package slfp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CFG_IDX_W = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 2'd2;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hF1;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hDD;
	localparam logic [BYTE_W-1:0] MAX_LENGTH_RST  = 8'd250;

	// Two packet id bytes are counted in the length byte.
	localparam logic [BYTE_W-1:0] MIN_LENGTH = 8'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] sync_first;
		logic [BYTE_W-1:0] sync_second;
		logic [BYTE_W-1:0] max_length;
	} slfp_cfg_t;

	typedef struct packed {
		logic              is_header;
		logic [BYTE_W-1:0] message_length;
		logic [BYTE_W-1:0] payload_byte;
		logic              last;
	} slfp_result_t;

endpackage

// ----- hw/rtl/slfp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// slfp_cfg_regs
// Configuration registers of the frame parser, written through a plain port.
// ----------------------------------------------------------------------------
module slfp_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [slfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [slfp_pkg::BYTE_W-1:0]      cfg_data,
	output slfp_pkg::slfp_cfg_t              cfg
);
	import slfp_pkg::*;

	slfp_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= SYNC_FIRST_RST;
			cfg_q.sync_second <= SYNC_SECOND_RST;
			cfg_q.max_length  <= MAX_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_data;
				REG_SYNC_SECOND: cfg_q.sync_second <= cfg_data;
				REG_MAX_LENGTH:  cfg_q.max_length  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/slfp_parser.sv -----
// ----------------------------------------------------------------------------
// slfp_parser
// Frame state machine: sync hunt, length check, body byte count.
// ----------------------------------------------------------------------------
module slfp_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  slfp_pkg::slfp_cfg_t          cfg,
	input  logic [slfp_pkg::BYTE_W-1:0]  rx_byte,
	input  logic                         advance,
	output logic                         res_valid,
	output slfp_pkg::slfp_result_t       res
);
	import slfp_pkg::*;

	localparam logic [1:0] PH_HUNT  = 2'd0;
	localparam logic [1:0] PH_ARMED = 2'd1;
	localparam logic [1:0] PH_LEN   = 2'd2;
	localparam logic [1:0] PH_BODY  = 2'd3;

	logic [1:0]        phase_q, phase_d;
	logic [BYTE_W-1:0] bytes_left_q, bytes_left_d;
	logic              len_ok;
	logic              fin;

	assign len_ok = (rx_byte <= cfg.max_length) && (rx_byte >= MIN_LENGTH);
	assign fin    = (bytes_left_q <= 8'd1);

	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		res_valid    = 1'b0;
		res          = '0;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == cfg.sync_first) phase_d = PH_ARMED;
			end
			PH_ARMED: begin
				// The second sync byte has priority over a repeated first one.
				if (rx_byte == cfg.sync_second) phase_d = PH_LEN;
				else if (rx_byte == cfg.sync_first) phase_d = PH_ARMED;
				else phase_d = PH_HUNT;
			end
			PH_LEN: begin
				if (len_ok) begin
					phase_d            = PH_BODY;
					bytes_left_d       = rx_byte;
					res_valid          = 1'b1;
					res.is_header      = 1'b1;
					res.message_length = rx_byte - MIN_LENGTH;
				end else begin
					phase_d      = PH_HUNT;
					bytes_left_d = '0;
				end
			end
			PH_BODY: begin
				res_valid        = 1'b1;
				res.payload_byte = rx_byte;
				res.last         = fin;
				if (fin) begin
					phase_d      = PH_HUNT;
					bytes_left_d = '0;
				end else begin
					bytes_left_d = bytes_left_q - 8'd1;
				end
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			bytes_left_q <= '0;
		end else if (advance) begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
		end
	end

	// The count is only live while a body is being read.
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_BODY) |-> (bytes_left_q == '0))
		else $error("slfp_parser: byte count nonzero outside a body");

	a_count_body: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (bytes_left_q != '0))
		else $error("slfp_parser: body phase with zero byte count");

	a_header_enters_body: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == PH_LEN && res_valid) |=>
		(phase_q == PH_BODY && bytes_left_q >= MIN_LENGTH))
		else $error("slfp_parser: header not followed by body phase");

endmodule

// ----- hw/rtl/sync_length_frame_parser.sv -----
// ----------------------------------------------------------------------------
// sync_length_frame_parser
// Deframer for sync-word, length-prefixed frames on a byte stream.
// ----------------------------------------------------------------------------
// Received bytes enter on the s_axis channel, one byte per transaction. The
// block hunts for the two-byte sync word, checks the length byte against
// max_length and the two id bytes, and then emits on m_axis one header
// transaction (tuser high, message length in tdata[7:0]) followed by one
// transaction per body byte (tuser low, byte in tdata[15:8]); tlast marks the
// final body byte. Sync bytes, length bytes and dropped frames give no output.
// The user must write the three registers on the cfg port only while no byte
// is in flight; the block itself does not enforce this. The input register
// captures the byte when it is accepted, and the parser logic loads the output
// register from it once the output register is free. One byte is taken every
// cycle while the output is not stalled by the receiver.
// Reset returns the parser to sync hunting and loads register defaults.
// When the receiver stalls, the result waits in the output register and one
// more byte is held in the input register; bytes that give no result are
// still consumed while the output is stalled.
// ----------------------------------------------------------------------------
module sync_length_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,    // [7:0] message_length, [15:8] payload_byte
	output logic        m_axis_tuser,    // [0] is_header
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import slfp_pkg::*;

	slfp_cfg_t         cfg;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	slfp_result_t      res_s2;
	logic              res_valid;
	slfp_result_t      res;
	logic              out_free;
	logic              take_s1;

	slfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign out_free      = !valid_s2 || m_axis_tready;
	assign take_s1       = valid_s1 && (out_free || !res_valid);
	assign s_axis_tready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) byte_s1 <= s_axis_tdata;
	end

	slfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.rx_byte   (byte_s1),
		.advance   (take_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= take_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && take_s1 && res_valid) res_s2 <= res;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.payload_byte, res_s2.message_length};
	assign m_axis_tuser  = res_s2.is_header;
	assign m_axis_tlast  = res_s2.last;

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sync/length frame parser.
// ----------------------------------------------------------------------------
// A byte-level model of the parser predicts the header and payload
// transactions for every byte accepted on s_axis. Each m_axis transaction is
// compared with the oldest prediction. The stimulus starts with hand-picked
// frames: repeated sync bytes, a broken sync word, lengths below the minimum
// and above the limit, and the shortest frame. After that come random frames
// under several register settings. Both stream sides idle and stall at random.
// The registers are only rewritten once the parser has drained.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import slfp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 6;
	localparam int PRINT_LIMIT    = 100;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_ARMED,
		PH_LENGTH,
		PH_BODY
	} parse_phase_e;

	class frame_scoreboard;
		logic [7:0]   sync_first;
		logic [7:0]   sync_second;
		logic [7:0]   max_length;
		parse_phase_e phase;
		logic [7:0]   bytes_left;
		slfp_result_t pending_results[$];
		int           errors;

		function new();
			sync_first  = SYNC_FIRST_RST;
			sync_second = SYNC_SECOND_RST;
			max_length  = MAX_LENGTH_RST;
			phase       = PH_HUNT;
			bytes_left  = '0;
			errors      = 0;
		endfunction

		function void set_regs(logic [7:0] sf, logic [7:0] ss, logic [7:0] ml);
			sync_first  = sf;
			sync_second = ss;
			max_length  = ml;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// Advances the parse state by one accepted byte and queues the
		// transaction that it produces, if any.
		function void parse_byte(logic [7:0] b);
			slfp_result_t r;
			r = '0;
			case (phase)
				PH_HUNT: begin
					if (b == sync_first)
						phase = PH_ARMED;
				end
				PH_ARMED: begin
					// The second sync byte wins when both sync bytes are equal.
					if (b == sync_second)
						phase = PH_LENGTH;
					else if (b != sync_first)
						phase = PH_HUNT;
				end
				PH_LENGTH: begin
					if (b > max_length || b < MIN_LENGTH) begin
						phase      = PH_HUNT;
						bytes_left = '0;
					end else begin
						bytes_left         = b;
						phase              = PH_BODY;
						r.is_header        = 1'b1;
						r.message_length   = b - MIN_LENGTH;
						pending_results.push_back(r);
					end
				end
				default: begin
					r.payload_byte = b;
					r.last         = (bytes_left <= 8'd1);
					if (r.last) begin
						bytes_left = '0;
						phase      = PH_HUNT;
					end else begin
						bytes_left = bytes_left - 8'd1;
					end
					pending_results.push_back(r);
				end
			endcase
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("ERROR at %0t: %s", $realtime, msg);
		endtask

		task check_result(slfp_result_t got);
			slfp_result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected transaction hdr=%0b len=%0d byte=%02h last=%0b",
					got.is_header, got.message_length, got.payload_byte, got.last));
				return;
			end
			want = pending_results.pop_front();
			if (got.is_header !== want.is_header)
				report($sformatf("is_header %0b, expected %0b", got.is_header, want.is_header));
			if (got.message_length !== want.message_length)
				report($sformatf("message_length %0d, expected %0d",
					got.message_length, want.message_length));
			if (got.payload_byte !== want.payload_byte)
				report($sformatf("payload_byte %02h, expected %02h",
					got.payload_byte, want.payload_byte));
			if (got.last !== want.last)
				report($sformatf("last %0b, expected %0b", got.last, want.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	frame_scoreboard sb;
	logic [7:0]      directed_bytes[$];
	int              bytes_sent;
	bit              tx_calm;
	int              rx_hold;
	int              rx_calm;
	int              idle_cycles;
	slfp_result_t    got;

	sync_length_frame_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		sb.parse_byte(b);
		bytes_sent++;
	endtask

	// One frame under the current registers, sometimes preceded by noise or
	// by a sync word that breaks off after its first byte.
	task automatic send_frame();
		int         r;
		int         n;
		int         len_top;
		logic [7:0] len;
		tx_calm = ($urandom_range(0, 99) < 20);
		r = $urandom_range(0, 99);
		if (r < 15) begin
			n = $urandom_range(1, 4);
			repeat (n) send_byte(8'($urandom_range(0, 255)));
		end else if (r < 25) begin
			send_byte(sb.sync_first);
			send_byte(8'($urandom_range(0, 255)));
		end
		send_byte(sb.sync_first);
		send_byte(sb.sync_second);
		len_top = (sb.max_length < 8'd12) ? int'(sb.max_length) : 12;
		r = $urandom_range(0, 99);
		if (r < 80)
			len = 8'($urandom_range(int'(MIN_LENGTH), len_top));
		else if (r < 86)
			len = sb.max_length;
		else if (r < 93 || sb.max_length == 8'hFF)
			len = 8'($urandom_range(0, 1));
		else
			len = 8'($urandom_range(int'(sb.max_length) + 1, 255));
		send_byte(len);
		if (len >= MIN_LENGTH && len <= sb.max_length) begin
			repeat (len) begin
				r = $urandom_range(0, 99);
				if (r < 10)
					send_byte(sb.sync_first);
				else if (r < 20)
					send_byte(sb.sync_second);
				else
					send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic run_random(input int goal);
		int stop_at;
		stop_at = bytes_sent + goal;
		while (bytes_sent < stop_at)
			send_frame();
	endtask

	// Sender goes quiet until every predicted transaction has come out, then
	// gives bytes that produce no output time to leave the pipeline.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [7:0] sf, input logic [7:0] ss,
		input logic [7:0] ml);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SYNC_FIRST;
		cfg_data  <= sf;
		@(posedge clk);
		cfg_index <= REG_SYNC_SECOND;
		cfg_data  <= ss;
		@(posedge clk);
		cfg_index <= REG_MAX_LENGTH;
		cfg_data  <= ml;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_regs(sf, ss, ml);
	endtask

	// Receiver: checks each output transaction and stalls at random, with
	// occasional stretches of steady readiness.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.is_header      = m_axis_tuser;
			got.message_length = m_axis_tdata[7:0];
			got.payload_byte   = m_axis_tdata[15:8];
			got.last           = m_axis_tlast;
			sb.check_result(got);
		end
		if (rx_calm > 0) begin
			rx_calm--;
			m_axis_tready <= 1'b1;
		end else if (rx_hold > 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 99) < 3)
				rx_calm = $urandom_range(30, 120);
			else if ($urandom_range(0, 99) < 30)
				rx_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		sb            = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_SYNC_FIRST;
		cfg_data      = '0;
		bytes_sent    = 0;
		tx_calm       = 1'b0;
		rx_hold       = 0;
		rx_calm       = 0;
		idle_cycles   = 0;

		directed_bytes = {
			8'h00, 8'hFF,
			// Repeated first sync byte, then the shortest frame.
			SYNC_FIRST_RST, SYNC_FIRST_RST, SYNC_SECOND_RST, MIN_LENGTH, 8'hAA, 8'h55,
			// Lengths below the minimum and above the limit are dropped.
			SYNC_FIRST_RST, SYNC_SECOND_RST, 8'd0,
			SYNC_FIRST_RST, SYNC_SECOND_RST, 8'd1,
			SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_LENGTH_RST + 8'd1,
			// Broken sync word; a lone second sync byte is ignored.
			SYNC_FIRST_RST, 8'h33, SYNC_SECOND_RST,
			// Body bytes, the last of which looks like a sync byte.
			SYNC_FIRST_RST, SYNC_SECOND_RST, 8'd3, 8'h00, 8'hFF, SYNC_FIRST_RST
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);
		run_random(150);
		drain();

		program_regs(8'h00, 8'hFF, 8'd2);
		run_random(120);
		drain();

		program_regs(8'hFF, 8'h00, 8'd255);
		run_random(150);
		drain();

		// Equal sync bytes: two in a row complete the sync word.
		program_regs(8'h5A, 8'h5A, 8'($urandom_range(2, 255)));
		run_random(110);
		drain();

		repeat (2) begin
			program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(2, 255)));
			run_random(100);
			drain();
		end

		if (sb.errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
